FILE: src/cap_pkg.sv
// Shared types and constants for the circular aperture photometry block.
`timescale 1ns / 1ps
package cap_pkg;
	localparam int NUM_APERTURES_DEF = 4;
	localparam int IMAGE_WIDTH_DEF = 64;
	localparam int IMAGE_HEIGHT_DEF = 64;
	localparam int FLUX_W = 53;
	localparam int VAR_W = 60;
	localparam int ERR_W = 30;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_X = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAC_Y = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUBPIX = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIAM_0 = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIAM_1 = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIAM_2 = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DIAM_3 = 8'd6;

	// Queue entry from front to back: one classified pixel
	typedef struct packed {
		logic signed [23:0] value;
		logic [15:0] rms;
		logic signed [15:0] dx0; // xm - cx + half, 1/512 px
		logic signed [15:0] dy0;
		logic [3:0][1:0] cls; // per aperture: 0 none, 1 sub, 2 full
		logic frame_end;
	} pix_item_t;

	localparam logic [1:0] CLS_NONE = 2'd0;
	localparam logic [1:0] CLS_SUB = 2'd1;
	localparam logic [1:0] CLS_FULL = 2'd2;
endpackage

FILE: src/cap_front.sv
// Front end: pixel position counters and per-aperture area classification.
`timescale 1ns / 1ps
module cap_front #(
	parameter int NUM_APERTURES = 4,
	parameter int IMAGE_WIDTH = 64,
	parameter int IMAGE_HEIGHT = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [23:0] pixel_value,
	input  logic [15:0] pixel_rms,
	input  logic [7:0] frac_x,
	input  logic [7:0] frac_y,
	input  logic [2:0] s_eff,
	input  logic [3:0][11:0] diam,
	output logic q_valid,
	input  logic q_ready,
	output cap_pkg::pix_item_t q_item
);
	import cap_pkg::*;
	localparam int CW = $clog2(IMAGE_WIDTH);
	localparam int RW = $clog2(IMAGE_HEIGHT);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic signed [17:0] cx, cy, xm, ym, ax, bx, ay, by;
	logic [16:0] nx, fx, ny, fy;
	logic [16:0] nx_s1, fx_s1, ny_s1, fy_s1;
	logic [34:0] near2_s2, far2_s2;
	logic signed [23:0] val_s1, val_s2;
	logic [15:0] rms_s1, rms_s2;
	logic signed [15:0] dx_s1, dy_s1, dx_s2, dy_s2;
	logic end_s1, end_s2, v_s1, v_s2;
	logic [8:0] half;
	logic adv, take, last_col, last_row;
	logic [3:0][1:0] cls;
	logic [35:0] r2;
	logic keep;

	// Stall the short pipe when the queue is full
	assign adv = !(v_s2 && !q_ready);
	assign in_ready = adv;
	assign take = in_valid && in_ready;
	assign last_col = (col_q == CW'(IMAGE_WIDTH - 1));
	assign last_row = (row_q == RW'(IMAGE_HEIGHT - 1));

	assign half = 9'(256 >> s_eff);
	assign cx = 18'($signed({1'b0, frac_x, 1'b0})) + 18'(256 * (IMAGE_WIDTH - 1));
	assign cy = 18'($signed({1'b0, frac_y, 1'b0})) + 18'(256 * (IMAGE_HEIGHT - 1));
	assign xm = $signed({1'b0, 17'(col_q) << 9}) - 18'sd256;
	assign ym = $signed({1'b0, 17'(row_q) << 9}) - 18'sd256;
	assign ax = cx - xm;
	assign bx = xm + 18'sd512 - cx;
	assign ay = cy - ym;
	assign by = ym + 18'sd512 - cy;

	// Per-axis nearest and farthest distance
	always_comb begin
		logic [16:0] aa, bb;
		aa = ax[17] ? 17'(-ax) : 17'(ax);
		bb = bx[17] ? 17'(-bx) : 17'(bx);
		fx = (aa > bb) ? aa : bb;
		nx = ax[17] ? 17'(-ax) : (bx[17] ? 17'(-bx) : 17'd0);
		aa = ay[17] ? 17'(-ay) : 17'(ay);
		bb = by[17] ? 17'(-by) : 17'(by);
		fy = (aa > bb) ? aa : bb;
		ny = ay[17] ? 17'(-ay) : (by[17] ? 17'(-by) : 17'd0);
	end

	// Advance raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (take) begin
				col_q <= last_col ? '0 : col_q + CW'(1);
				if (last_col) row_q <= last_row ? '0 : row_q + RW'(1);
			end
			if (adv) begin
				v_s1 <= take;
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1 capture, stage 2 squares
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1 <= nx; fx_s1 <= fx; ny_s1 <= ny; fy_s1 <= fy;
			val_s1 <= pixel_value; rms_s1 <= pixel_rms;
			dx_s1 <= 16'(xm - cx + 18'(half));
			dy_s1 <= 16'(ym - cy + 18'(half));
			end_s1 <= last_col && last_row;
			near2_s2 <= 35'(nx_s1 * nx_s1) + 35'(ny_s1 * ny_s1);
			far2_s2 <= 35'(fx_s1 * fx_s1) + 35'(fy_s1 * fy_s1);
			val_s2 <= val_s1; rms_s2 <= rms_s1;
			dx_s2 <= dx_s1; dy_s2 <= dy_s1; end_s2 <= end_s1;
		end
	end

	// Classify from the largest used aperture down
	always_comb begin
		keep = 1'b1;
		r2 = '0;
		for (int ap = 3; ap >= 0; ap--) begin
			cls[ap] = CLS_NONE;
			r2 = 36'(diam[ap]) * 36'(diam[ap]) << 8;
			if (keep && ap < NUM_APERTURES) begin
				if (36'(near2_s2) > r2) keep = 1'b0;
				else if (36'(far2_s2) >= r2) cls[ap] = CLS_SUB;
				else cls[ap] = CLS_FULL;
			end
		end
	end

	assign q_valid = v_s2;
	always_comb begin
		q_item.value = val_s2;
		q_item.rms = rms_s2;
		q_item.dx0 = dx_s2;
		q_item.dy0 = dy_s2;
		q_item.cls = cls;
		q_item.frame_end = end_s2;
	end
endmodule

FILE: src/cap_queue.sv
// Small FIFO between the classifier and the accumulator.
`timescale 1ns / 1ps
module cap_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cap_pkg::pix_item_t wr_item,
	output logic rd_valid,
	input  logic rd_ready,
	output cap_pkg::pix_item_t rd_item
);
	import cap_pkg::*;
	pix_item_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_item = mem_q[rp_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_item;
	end
endmodule

FILE: src/cap_back.sv
// Back end: subgrid counting, accumulation, square root and result output.
`timescale 1ns / 1ps
module cap_back #(
	parameter int NUM_APERTURES = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_ready,
	input  cap_pkg::pix_item_t q_item,
	input  logic [2:0] s_eff,
	input  logic [3:0][11:0] diam,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] aperture_index,
	output logic signed [52:0] flux,
	output logic [29:0] flux_error,
	output logic last
);
	import cap_pkg::*;
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_AP = 4'd1;
	localparam logic [3:0] ST_SUB = 4'd2;
	localparam logic [3:0] ST_MUL = 4'd3;
	localparam logic [3:0] ST_ACC = 4'd4;
	localparam logic [3:0] ST_SQ = 4'd5;
	localparam logic [3:0] ST_OUT = 4'd6;
	localparam logic [3:0] ST_ROOT = 4'd7;
	localparam logic [1:0] TOP = 2'(NUM_APERTURES - 1);

	logic [3:0] st_q;
	pix_item_t it_q;
	logic [1:0] ap_q;
	logic [3:0] a_q, b_q;
	logic [8:0] k_q;
	logic [35:0] r2_q;
	logic signed [15:0] dx_q, dy_q;
	logic [52:0] facc_q [4];
	logic [59:0] vacc_q [4];
	logic signed [52:0] fprod_q;
	logic [59:0] vprod_q;
	logic [31:0] rk_q;
	logic [59:0] sv_q, sr_q, sb_q;
	logic [4:0] sn_q;
	logic [8:0] stp;
	logic [3:0] nm1;
	logic [33:0] d2;
	logic [59:0] trial;

	assign stp = 9'(512 >> s_eff);
	assign nm1 = 4'((16'd1 << s_eff) - 16'd1);
	assign d2 = 34'($signed(dx_q) * $signed(dx_q)) + 34'($signed(dy_q) * $signed(dy_q));
	assign trial = sr_q + sb_q;
	assign q_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign aperture_index = ap_q;
	assign flux = facc_q[ap_q];
	assign flux_error = 30'(sr_q);
	assign last = (ap_q == TOP);

	// Sequence pixel apertures, subgrid tests and frame output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ap_q <= '0;
			for (int i = 0; i < 4; i++) begin
				facc_q[i] <= '0;
				vacc_q[i] <= '0;
			end
		end else begin
			case (st_q)
				ST_IDLE: if (q_valid) begin
					it_q <= q_item;
					ap_q <= TOP;
					st_q <= ST_AP;
				end
				ST_AP: begin
					k_q <= (it_q.cls[ap_q] == CLS_FULL) ? 9'(1) << (2 * s_eff) : 9'd0;
					r2_q <= 36'(diam[ap_q]) * 36'(diam[ap_q]) << 8;
					a_q <= '0; b_q <= '0;
					dx_q <= it_q.dx0; dy_q <= it_q.dy0;
					st_q <= (it_q.cls[ap_q] == CLS_SUB) ? ST_SUB : ST_MUL;
				end
				ST_SUB: begin
					// Test one subpixel centre per cycle
					if (36'(d2) < r2_q) k_q <= k_q + 9'd1;
					if (a_q == nm1) begin
						a_q <= '0;
						dx_q <= it_q.dx0;
						dy_q <= dy_q + $signed({7'd0, stp});
						if (b_q == nm1) st_q <= ST_MUL;
						b_q <= b_q + 4'd1;
					end else begin
						a_q <= a_q + 4'd1;
						dx_q <= dx_q + $signed({7'd0, stp});
					end
				end
				ST_MUL: begin
					fprod_q <= 53'($signed(it_q.value) * $signed({1'b0, k_q}))
						<<< (5'd16 - 5'(2 * s_eff));
					rk_q <= 32'(it_q.rms) * 32'(k_q);
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					vprod_q <= 60'(64'(rk_q) * 64'(rk_q)) << (5'd16 - 5'(4 * s_eff));
					st_q <= ST_SQ;
				end
				ST_SQ: begin
					facc_q[ap_q] <= facc_q[ap_q] + fprod_q;
					vacc_q[ap_q] <= vacc_q[ap_q] + vprod_q;
					if (ap_q != 2'd0) begin
						ap_q <= ap_q - 2'd1;
						st_q <= ST_AP;
					end else if (it_q.frame_end) begin
						sv_q <= vacc_q[0] + vprod_q;
						sr_q <= '0; sb_q <= 60'(1) << 58; sn_q <= 5'd30;
						st_q <= ST_ROOT;
					end else st_q <= ST_IDLE;
				end
				ST_ROOT: begin
					// Restoring square root, one result bit per cycle
					if (sn_q == 5'd0) st_q <= ST_OUT;
					else begin
						if (sv_q >= trial) begin
							sv_q <= sv_q - trial;
							sr_q <= (sr_q >> 1) + sb_q;
						end else sr_q <= sr_q >> 1;
						sb_q <= sb_q >> 2;
						sn_q <= sn_q - 5'd1;
					end
				end
				ST_OUT: if (out_ready) begin
					facc_q[ap_q] <= '0;
					vacc_q[ap_q] <= '0;
					if (ap_q == TOP) st_q <= ST_IDLE;
					else begin
						ap_q <= ap_q + 2'd1;
						sv_q <= vacc_q[ap_q + 2'd1];
						sr_q <= '0; sb_q <= 60'(1) << 58; sn_q <= 5'd30;
						st_q <= ST_ROOT;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: src/circular_aperture_photometry.sv
// Top level of the circular aperture photometry block.
// Pixels enter on in_valid/in_ready in raster order (pixel_value, pixel_rms);
// internal counters track column and row. Configuration writes arrive on
// cfg_valid/cfg_ready with cfg_index and cfg_data and are taken every cycle;
// write them only while the block is idle.
// The front classifies each pixel per aperture in a two-stage pipe and
// queues it; the back picks up an item, then handles apertures one after
// another: ST_AP, then ST_SUB for a boundary pixel's n*n subgrid (n up to 16)
// walked by the one subgrid tester, then ST_MUL, ST_ACC and ST_SQ.
// After the last pixel of a frame, NUM_APERTURES results leave on
// out_valid/out_ready in aperture order, each after a restoring square root;
// last marks the final one. A stalled receiver holds the result and fills the
// queue, after which in_ready drops. Reset clears counters, accumulators and
// registers (subpix_q resets to 2).
`timescale 1ns / 1ps
module circular_aperture_photometry #(
	parameter int NUM_APERTURES = cap_pkg::NUM_APERTURES_DEF,
	parameter int IMAGE_WIDTH = cap_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = cap_pkg::IMAGE_HEIGHT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [23:0] pixel_value,
	input  logic [15:0] pixel_rms,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cap_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] aperture_index,
	output logic signed [52:0] flux,
	output logic [29:0] flux_error,
	output logic last
);
	import cap_pkg::*;
	logic [7:0] frac_x_q, frac_y_q;
	logic [2:0] subpix_q, s_eff;
	logic [3:0][11:0] diam_q;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	pix_item_t f_item, b_item;

	assign cfg_ready = 1'b1;
	assign s_eff = (subpix_q > 3'd4) ? 3'd4 : subpix_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_x_q <= '0;
			frac_y_q <= '0;
			subpix_q <= 3'd2;
			diam_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAC_X: frac_x_q <= cfg_data[7:0];
				REG_FRAC_Y: frac_y_q <= cfg_data[7:0];
				REG_SUBPIX: subpix_q <= cfg_data[2:0];
				REG_DIAM_0: diam_q[0] <= cfg_data;
				REG_DIAM_1: diam_q[1] <= cfg_data;
				REG_DIAM_2: diam_q[2] <= cfg_data;
				REG_DIAM_3: diam_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unused apertures never count
	logic [3:0][11:0] diam_eff;
	always_comb begin
		for (int i = 0; i < 4; i++) diam_eff[i] = (i < NUM_APERTURES) ? diam_q[i] : 12'd0;
	end

	cap_front #(.NUM_APERTURES(NUM_APERTURES), .IMAGE_WIDTH(IMAGE_WIDTH),
		.IMAGE_HEIGHT(IMAGE_HEIGHT)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .pixel_value, .pixel_rms,
		.frac_x(frac_x_q), .frac_y(frac_y_q), .s_eff, .diam(diam_eff),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_item(f_item)
	);

	cap_queue u_queue (
		.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(f_item),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_item(b_item)
	);

	cap_back #(.NUM_APERTURES(NUM_APERTURES)) u_back (
		.clk, .arst_n, .q_valid(bq_valid), .q_ready(bq_ready), .q_item(b_item),
		.s_eff, .diam(diam_eff), .out_valid, .out_ready, .aperture_index,
		.flux, .flux_error, .last
	);
endmodule

FILE: bench/tb_circular_aperture_photometry.sv
// Self-checking testbench for circular_aperture_photometry: whole frames, checked per aperture.
`timescale 1ns / 1ps
module tb_circular_aperture_photometry;
	import cap_pkg::*;

	localparam int IMG_W = IMAGE_WIDTH_DEF;
	localparam int IMG_H = IMAGE_HEIGHT_DEF;
	localparam int N_AP = NUM_APERTURES_DEF;
	localparam int N_RANDOM_FRAMES = 5;
	// Worst case is when every aperture walks a 16x16 subgrid
	localparam longint CYCLE_LIMIT = longint'(6 + N_RANDOM_FRAMES) * IMG_W * IMG_H * 4200;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd7;

	typedef enum int {FILL_RANDOM, FILL_CONST, FILL_ALT} fill_kind_e;

	typedef struct {
		bit write_cfg;
		logic [CFG_DATA_W-1:0] cfg[7];
		fill_kind_e fill;
		logic signed [23:0] value;
		logic [15:0] rms;
		bit typed;
		logic signed [52:0] flux;
		logic [29:0] err;
	} frame_row_t;

	typedef struct {
		logic [1:0] ap;
		logic signed [52:0] flux;
		logic [29:0] err;
		logic last;
	} aperture_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic signed [23:0] pixel_value;
	logic [15:0] pixel_rms;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic out_valid, out_ready;
	logic [1:0] aperture_index;
	logic signed [52:0] flux;
	logic [29:0] flux_error;
	logic last;

	circular_aperture_photometry u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel_value(pixel_value), .pixel_rms(pixel_rms),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.aperture_index(aperture_index), .flux(flux),
		.flux_error(flux_error), .last(last)
	);

	// Shadow configuration and frame state
	logic [7:0] frac_x, frac_y;
	logic [2:0] subgrid_log2;
	logic [11:0] diam[N_AP];
	int col, row;
	logic signed [52:0] flux_sum[N_AP];
	logic [59:0] var_sum[N_AP];
	aperture_result_t pending_apertures[$];

	frame_row_t plan[6];
	frame_row_t cur_row;
	int idle_mode;
	int errors;
	int results_seen;
	int frames_sent;
	longint cycles;

	// Generate clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what);
		errors++;
		$display("MISMATCH @%0t: %s", $realtime, what);
	endtask

	function automatic void axis_span(input longint lo, input longint c,
			output longint nearest, output longint farthest);
		longint a, b;
		a = c - lo;
		b = lo + 512 - c;
		if (a < 0) a = -a;
		if (b < 0) b = -b;
		farthest = (a > b) ? a : b;
		if (c < lo) nearest = lo - c;
		else if (c > lo + 512) nearest = c - lo - 512;
		else nearest = 0;
	endfunction

	function automatic logic [29:0] floor_sqrt(input logic [59:0] v);
		logic [63:0] r, t;
		r = 0;
		for (int b = 29; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= {4'd0, v}) r = t;
		end
		return r[29:0];
	endfunction

	// Accumulate one pixel; on the frame's last pixel queue the aperture results
	function automatic void accumulate_pixel(input logic signed [23:0] v, input logic [15:0] r);
		int s;
		longint n, stp, half, full, cx, cy, xm, ym, nx, fx, ny, fy, near2, far2, r2, k, dx, dy;
		bit keep;
		aperture_result_t res;
		s = (subgrid_log2 > 4) ? 4 : subgrid_log2;
		n = 1 << s;
		stp = 512 >> s;
		half = 256 >> s;
		full = n * n;
		cx = longint'(frac_x) * 2 + 256 * (IMG_W - 1);
		cy = longint'(frac_y) * 2 + 256 * (IMG_H - 1);
		xm = longint'(col) * 512 - 256;
		ym = longint'(row) * 512 - 256;
		axis_span(xm, cx, nx, fx);
		axis_span(ym, cy, ny, fy);
		near2 = nx * nx + ny * ny;
		far2 = fx * fx + fy * fy;
		keep = 1'b1;
		for (int ap = N_AP - 1; ap >= 0; ap--) begin
			k = 0;
			if (keep) begin
				r2 = (longint'(diam[ap]) * 16) * (longint'(diam[ap]) * 16);
				if (near2 > r2) keep = 1'b0;
				else if (far2 >= r2) begin
					for (int b = 0; b < n; b++) begin
						dy = ym - cy + half + b * stp;
						for (int a = 0; a < n; a++) begin
							dx = xm - cx + half + a * stp;
							if (dx * dx + dy * dy < r2) k++;
						end
					end
				end else k = full;
			end
			flux_sum[ap] = 53'(flux_sum[ap] + longint'(v) * (k << (16 - 2 * s)));
			var_sum[ap] = 60'(var_sum[ap]
				+ ((64'(r) * 64'(r) * 64'(k) * 64'(k)) << (16 - 4 * s)));
		end
		if (col == IMG_W - 1) begin
			col = 0;
			if (row == IMG_H - 1) begin
				row = 0;
				for (int ap = 0; ap < N_AP; ap++) begin
					res.ap = 2'(ap);
					res.flux = cur_row.typed ? cur_row.flux : flux_sum[ap];
					res.err = cur_row.typed ? cur_row.err : floor_sqrt(var_sum[ap]);
					res.last = (ap == N_AP - 1);
					pending_apertures.push_back(res);
					flux_sum[ap] = 0;
					var_sum[ap] = 0;
				end
			end else row++;
		end else col++;
	endfunction

	// Track accepted transactions, check results, watch the cycle budget
	always @(posedge clk) begin
		aperture_result_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAC_X: frac_x = cfg_data[7:0];
					REG_FRAC_Y: frac_y = cfg_data[7:0];
					REG_SUBPIX: subgrid_log2 = cfg_data[2:0];
					REG_DIAM_0: diam[0] = cfg_data;
					REG_DIAM_1: diam[1] = cfg_data;
					REG_DIAM_2: diam[2] = cfg_data;
					REG_DIAM_3: diam[3] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) accumulate_pixel(pixel_value, pixel_rms);
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_apertures.size() == 0) report("result with nothing expected");
				else begin
					e = pending_apertures.pop_front();
					if (aperture_index !== e.ap)
						report($sformatf("aperture_index %0d, want %0d", aperture_index, e.ap));
					if (flux !== e.flux)
						report($sformatf("ap %0d flux %0d, want %0d", e.ap, flux, e.flux));
					if (flux_error !== e.err)
						report($sformatf("ap %0d flux_error %0d, want %0d", e.ap,
							flux_error, e.err));
					if (last !== e.last)
						report($sformatf("ap %0d last %0b, want %0b", e.ap, last, e.last));
				end
			end
		end
	end

	// Stall the result channel according to the current idling phase
	always @(posedge clk) begin
		case (idle_mode)
			2: out_ready <= ($urandom_range(99) >= 84);
			3: out_ready <= ($urandom_range(99) >= 9);
			default: out_ready <= 1'b1;
		endcase
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Send one frame of pixels with the sender idling per phase
	task automatic send_frame(input frame_row_t fr);
		logic signed [23:0] v;
		logic [15:0] r;
		int sel;
		for (int p = 0; p < IMG_W * IMG_H; p++) begin
			case (fr.fill)
				FILL_CONST: begin
					v = fr.value;
					r = fr.rms;
				end
				FILL_ALT: begin
					v = p[0] ? 24'sh7FFFFF : 24'sh800000;
					r = p[0] ? 16'hFFFF : 16'h0000;
				end
				default: begin
					sel = $urandom_range(9);
					v = (sel == 0) ? 24'sh7FFFFF : (sel == 1) ? 24'sh800000 : 24'($urandom);
					r = (sel == 2) ? 16'hFFFF : 16'($urandom);
				end
			endcase
			in_valid <= 1'b1;
			pixel_value <= v;
			pixel_rms <= r;
			do @(posedge clk); while (!in_ready);
			while ((idle_mode == 1 && $urandom_range(99) < 84) ||
					(idle_mode == 3 && $urandom_range(99) < 9)) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Hold off until every result of the previous frame has come and the block settles
	task automatic drain;
		@(posedge clk);
		while (pending_apertures.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic run_frame(input frame_row_t fr);
		drain();
		cur_row = fr;
		if (fr.write_cfg) begin
			write_reg(REG_FRAC_X, fr.cfg[0]);
			write_reg(REG_FRAC_Y, fr.cfg[1]);
			write_reg(REG_SUBPIX, fr.cfg[2]);
			write_reg(REG_DIAM_0, fr.cfg[3]);
			write_reg(REG_DIAM_1, fr.cfg[4]);
			write_reg(REG_DIAM_2, fr.cfg[5]);
			write_reg(REG_DIAM_3, fr.cfg[6]);
			// Index past the register list must be ignored
			write_reg(8'($urandom_range(REG_UNUSED_FIRST, 255)), 12'($urandom));
		end
		send_frame(fr);
		frames_sent++;
		idle_mode = frames_sent % 4;
	endtask

	function automatic frame_row_t make_row(input bit wr, input int fx, input int fy,
			input int sp, input int d0, input int d1, input int d2, input int d3,
			input fill_kind_e fill);
		frame_row_t f;
		f.write_cfg = wr;
		f.cfg[0] = 12'(fx); f.cfg[1] = 12'(fy); f.cfg[2] = 12'(sp);
		f.cfg[3] = 12'(d0); f.cfg[4] = 12'(d1); f.cfg[5] = 12'(d2); f.cfg[6] = 12'(d3);
		f.fill = fill;
		f.value = 0;
		f.rms = 0;
		f.typed = 1'b0;
		f.flux = 0;
		f.err = 0;
		return f;
	endfunction

	function automatic int rand_diam();
		int sel;
		sel = $urandom_range(11);
		if (sel == 0) return 0;
		if (sel == 1) return 4095;
		return $urandom_range(400);
	endfunction

	// Main sequence
	initial begin
		frame_row_t fr;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		pixel_value <= '0;
		pixel_rms <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		out_ready <= 1'b0;
		idle_mode = 0;
		errors = 0;
		results_seen = 0;
		frames_sent = 0;
		cycles = 0;
		frac_x = 0; frac_y = 0; subgrid_log2 = 3'd2;
		col = 0; row = 0;
		for (int a = 0; a < N_AP; a++) begin
			diam[a] = 0;
			flux_sum[a] = 0;
			var_sum[a] = 0;
		end

		// Reset defaults: all diameters zero, so every aperture reads zero
		plan[0] = make_row(1'b0, 0, 0, 2, 0, 0, 0, 0, FILL_ALT);
		plan[0].typed = 1'b1;
		// Huge apertures cover the thumbnail fully: sums scale by 4096 pixels
		plan[1] = make_row(1'b1, 0, 0, 0, 4095, 4095, 4095, 4095, FILL_CONST);
		plan[1].value = 24'sh7FFFFF;
		plan[1].rms = 16'hFFFF;
		plan[1].typed = 1'b1;
		plan[1].flux = 53'sd8388607 <<< 28;
		plan[1].err = 30'd65535 << 14;
		plan[2] = plan[1];
		plan[2].value = 24'sh800000;
		plan[2].rms = 16'h0000;
		plan[2].flux = -(53'sd1 <<< 51);
		plan[2].err = 30'd0;
		// Nested exclusion, a zero diameter, finest subgrid
		plan[3] = make_row(1'b1, 255, 255, 4, 16, 0, 40, 8, FILL_RANDOM);
		// Centre on a pixel centre, out-of-range subgrid acting as 16
		plan[4] = make_row(1'b1, 128, 128, 7, 24, 48, 96, 200, FILL_RANDOM);
		// Largest aperture zero excludes everything else but the pixels that touch the centre
		plan[5] = make_row(1'b1, 0, 255, 1, 100, 64, 30, 0, FILL_RANDOM);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) run_frame(plan[i]);

		for (int f = 0; f < N_RANDOM_FRAMES; f++) begin
			fr = make_row(1'b1, 0, 0, 0, rand_diam(), rand_diam(), rand_diam(),
				rand_diam(), FILL_RANDOM);
			fr.cfg[0] = {4'($urandom), 8'($urandom)};
			fr.cfg[1] = {4'($urandom), 8'($urandom)};
			fr.cfg[2] = {9'($urandom), 3'($urandom_range(7))};
			run_frame(fr);
		end

		drain();
		repeat (140) @(posedge clk);

		$display("Covered %0d frames of %0dx%0d pixels under four idling phases,",
			frames_sent, IMG_W, IMG_H);
		$display("checking %0d aperture results against the predictor.", results_seen);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
